// File: src/rle_sprite_blitter_palette_rgb24_defines.svh
// Assertion macros used by the sprite blitter top level.
`ifndef RLE_SPRITE_BLITTER_PALETTE_RGB24_DEFINES_SVH
`define RLE_SPRITE_BLITTER_PALETTE_RGB24_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RSBP_ASSERT_NOW(lbl, clk_sig, rstn_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |-> (cons)) \
		else $error("rsbp assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RSBP_ASSERT_NEXT(lbl, clk_sig, rstn_sig, ante, cons) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rstn_sig) (ante) |=> (cons)) \
		else $error("rsbp assertion failed");

`endif

// File: src/rsbp_pkg.sv
// Package with types and constants of the sprite blitter.
`timescale 1ns / 1ps

package rsbp_pkg;

	localparam int ADDR_BITS     = 24;
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

	localparam int ADDR_SUM_W = 27;
	localparam logic [ADDR_SUM_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_SUM_W) ? '1 :
		ADDR_SUM_W'((64'd1 << ADDR_BITS) - 64'd1);

	localparam logic [7:0] CMD_END = 8'hFF;
	localparam logic [7:0] CMD_ROW = 8'hFE;

	localparam logic [2:0] REG_ORIGIN_X     = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y     = 3'd1;
	localparam logic [2:0] REG_FRAME_WIDTH  = 3'd2;
	localparam logic [2:0] REG_FRAME_HEIGHT = 3'd3;
	localparam logic [2:0] REG_ROW_STRIDE   = 3'd4;

	localparam logic [12:0] ORIGIN_X_RST     = 13'd0;
	localparam logic [12:0] ORIGIN_Y_RST     = 13'd0;
	localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
	localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;
	localparam logic [13:0] ROW_STRIDE_RST   = 14'd1920;

	typedef enum logic [1:0] {
		PH_CMD    = 2'd0,
		PH_COUNT  = 2'd1,
		PH_PIXELS = 2'd2
	} phase_t;

	typedef struct packed {
		logic [12:0] origin_x;
		logic [12:0] origin_y;
		logic [11:0] frame_width;
		logic [11:0] frame_height;
		logic [13:0] row_stride;
	} cfg_t;

	typedef struct packed {
		logic        hit;
		logic        done;
		logic [11:0] x;
		logic [11:0] y;
	} dec_res_t;

endpackage

// File: src/rle_sprite_blitter_palette_rgb24.sv
// Top level of the run-length sprite blitter with RGB24 palette output.
// The block takes one item per clock cycle whenever the output side keeps up. An accepted
// stream byte updates the decoder state at once and starts its palette read; in the stage
// after, the pixel address is formed from one multiply and add and loaded into the output
// register once the output is not stalled. A result passes through two register stages:
// the s1 registers with the registered palette read port, then the output register. A
// palette load issued in one cycle is seen by a pixel item accepted in any later cycle.
// The palette holds undefined data until each entry is loaded; there is no clearing pass
// after reset.
`timescale 1ns / 1ps
`include "rle_sprite_blitter_palette_rgb24_defines.svh"

module rle_sprite_blitter_palette_rgb24 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // data_byte [7:0], load_color [31:8]
	input  logic        s_axis_tuser,  // req_type [0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,  // pixel_addr [23:0], red [31:24], green [39:32],
	                                   // blue [47:40]
	output logic        m_axis_tuser,  // image_done [0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [13:0] cfg_data
);

	rsbp_pkg::cfg_t     cfg;
	rsbp_pkg::dec_res_t res;
	logic               in_acc;
	logic               stall_out;
	logic               valid_s1;
	logic               done_s1;
	logic [11:0]        x_s1;
	logic [11:0]        y_s1;
	logic [23:0]        color_s1;
	logic               out_valid_q;
	logic [47:0]        out_data_q;
	logic               out_done_q;
	logic [25:0]        prod;
	logic [13:0]        x3;
	logic [rsbp_pkg::ADDR_SUM_W-1:0] addr_sum;
	logic [rsbp_pkg::ADDR_SUM_W-1:0] addr_masked;

	assign cfg_ready     = 1'b1;
	assign stall_out     = out_valid_q && !m_axis_tready;
	assign s_axis_tready = !valid_s1 || !stall_out;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	rsbp_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	rsbp_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.acc       (in_acc),
		.req_type  (s_axis_tuser),
		.data_byte (s_axis_tdata[7:0]),
		.res       (res)
	);

	rsbp_palette u_palette (
		.clk     (clk),
		.wr_en   (in_acc && s_axis_tuser),
		.wr_addr (s_axis_tdata[rsbp_pkg::PAL_AW-1:0]),
		.wr_data (s_axis_tdata[31:8]),
		.rd_en   (in_acc && !s_axis_tuser),
		.rd_addr (s_axis_tdata[rsbp_pkg::PAL_AW-1:0]),
		.rd_data (color_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= in_acc && (res.hit || res.done);
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			done_s1 <= res.done;
			x_s1    <= res.x;
			y_s1    <= res.y;
		end
	end

	assign prod        = y_s1 * cfg.row_stride;
	assign x3          = {1'b0, x_s1, 1'b0} + {2'b00, x_s1};
	assign addr_sum    = rsbp_pkg::ADDR_SUM_W'(prod) + rsbp_pkg::ADDR_SUM_W'(x3);
	assign addr_masked = addr_sum & rsbp_pkg::ADDR_MASK;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!stall_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall_out && valid_s1) begin
			out_done_q <= done_s1;
			if (done_s1) begin
				out_data_q <= '0;
			end else begin
				out_data_q <= {color_s1[7:0], color_s1[15:8], color_s1[23:16],
					addr_masked[23:0]};
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_done_q;

	`RSBP_ASSERT_NOW(a_done_zero_payload, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 48'd0)
	`RSBP_ASSERT_NEXT(a_s1_holds_in_stall, clk, arst_n, valid_s1 && stall_out, valid_s1 && $stable(x_s1) && $stable(y_s1) && $stable(done_s1))
	`RSBP_ASSERT_NEXT(a_load_no_result, clk, arst_n, in_acc && s_axis_tuser, !valid_s1)

endmodule

// File: src/rsbp_cfg_regs.sv
// Configuration register file of the sprite blitter.
`timescale 1ns / 1ps

module rsbp_cfg_regs (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [2:0]      wr_index,
	input  logic [13:0]     wr_data,
	output rsbp_pkg::cfg_t  cfg
);

	rsbp_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x     <= rsbp_pkg::ORIGIN_X_RST;
			cfg_q.origin_y     <= rsbp_pkg::ORIGIN_Y_RST;
			cfg_q.frame_width  <= rsbp_pkg::FRAME_WIDTH_RST;
			cfg_q.frame_height <= rsbp_pkg::FRAME_HEIGHT_RST;
			cfg_q.row_stride   <= rsbp_pkg::ROW_STRIDE_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				rsbp_pkg::REG_ORIGIN_X:     cfg_q.origin_x     <= wr_data[12:0];
				rsbp_pkg::REG_ORIGIN_Y:     cfg_q.origin_y     <= wr_data[12:0];
				rsbp_pkg::REG_FRAME_WIDTH:  cfg_q.frame_width  <= wr_data[11:0];
				rsbp_pkg::REG_FRAME_HEIGHT: cfg_q.frame_height <= wr_data[11:0];
				rsbp_pkg::REG_ROW_STRIDE:   cfg_q.row_stride   <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/rsbp_palette.sv
// Palette memory with one write port and one registered read port.
`timescale 1ns / 1ps

module rsbp_palette (
	input  logic                       clk,
	input  logic                       wr_en,
	input  logic [rsbp_pkg::PAL_AW-1:0] wr_addr,
	input  logic [23:0]                wr_data,
	input  logic                       rd_en,
	input  logic [rsbp_pkg::PAL_AW-1:0] rd_addr,
	output logic [23:0]                rd_data
);

	logic [23:0] mem [rsbp_pkg::PALETTE_DEPTH];
	logic [23:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: src/rsbp_decode.sv
// Sprite stream decoder: phase, offsets, run counter and frame clipping.
`timescale 1ns / 1ps

module rsbp_decode (
	input  logic               clk,
	input  logic               arst_n,
	input  rsbp_pkg::cfg_t     cfg,
	input  logic               acc,
	input  logic               req_type,
	input  logic [7:0]         data_byte,
	output rsbp_pkg::dec_res_t res
);

	rsbp_pkg::phase_t phase_q, phase_d;
	logic [12:0] col_q, col_d;
	logic [12:0] row_q, row_d;
	logic [7:0]  run_q, run_d;
	logic [14:0] x_w;
	logic [14:0] y_w;
	logic        in_frame;
	logic [7:0]  run_dec;

	function automatic logic [12:0] sat_add(input logic [12:0] a, input logic [7:0] b);
		logic [13:0] s;
		s = {1'b0, a} + {6'd0, b};
		return s[13] ? 13'h1FFF : s[12:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= rsbp_pkg::PH_CMD;
			col_q   <= '0;
			row_q   <= '0;
			run_q   <= '0;
		end else begin
			phase_q <= phase_d;
			col_q   <= col_d;
			row_q   <= row_d;
			run_q   <= run_d;
		end
	end

	assign x_w = {{2{cfg.origin_x[12]}}, cfg.origin_x} + {2'b00, col_q};
	assign y_w = {{2{cfg.origin_y[12]}}, cfg.origin_y} + {2'b00, row_q};
	assign in_frame = !x_w[14] && !y_w[14]
		&& (x_w[13:0] < {2'b00, cfg.frame_width})
		&& (y_w[13:0] < {2'b00, cfg.frame_height});
	assign run_dec = run_q - 8'd1;

	always_comb begin
		phase_d = phase_q;
		col_d   = col_q;
		row_d   = row_q;
		run_d   = run_q;
		res     = '0;
		res.x   = x_w[11:0];
		res.y   = y_w[11:0];
		if (acc && !req_type) begin
			unique case (phase_q)
				rsbp_pkg::PH_COUNT: begin
					run_d   = data_byte;
					phase_d = (data_byte == 8'd0) ? rsbp_pkg::PH_CMD : rsbp_pkg::PH_PIXELS;
				end
				rsbp_pkg::PH_PIXELS: begin
					res.hit = in_frame;
					col_d   = sat_add(col_q, 8'd1);
					run_d   = run_dec;
					if (run_dec == 8'd0) begin
						phase_d = rsbp_pkg::PH_CMD;
					end
				end
				default: begin
					if (data_byte == rsbp_pkg::CMD_END) begin
						res.done = 1'b1;
						phase_d  = rsbp_pkg::PH_CMD;
						col_d    = '0;
						row_d    = '0;
						run_d    = '0;
					end else if (data_byte == rsbp_pkg::CMD_ROW) begin
						col_d   = '0;
						row_d   = sat_add(row_q, 8'd1);
						phase_d = rsbp_pkg::PH_CMD;
					end else begin
						col_d   = sat_add(col_q, data_byte);
						phase_d = rsbp_pkg::PH_COUNT;
					end
				end
			endcase
		end
	end

endmodule

// File: sim/testbench.sv
// Self-checking testbench for the run-length sprite blitter with palette and RGB24 output.
`timescale 1ns / 1ps

module testbench;

	localparam bit          REQ_STREAM   = 1'b0;
	localparam bit          REQ_LOAD     = 1'b1;
	localparam int          OFFSET_LIMIT = 8191;
	localparam int          STALL_LIMIT  = 5000;
	localparam int          HOLD_CYCLES  = 400;
	localparam int          PHASE_ITEMS  = 190;
	localparam int          PHASE_COUNT  = 8;

	typedef struct {
		logic [23:0] addr;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic        done;
	} pixel_write_t;

	class blit_scoreboard;
		logic [12:0]      org_x;
		logic [12:0]      org_y;
		logic [11:0]      fwidth;
		logic [11:0]      fheight;
		logic [13:0]      stride;
		rsbp_pkg::phase_t phase;
		int               col;
		int               row;
		logic [7:0]       run_left;
		logic [23:0]      palette [rsbp_pkg::PALETTE_DEPTH];
		pixel_write_t     pending_writes [$];
		int               errors;

		function new();
			org_x    = rsbp_pkg::ORIGIN_X_RST;
			org_y    = rsbp_pkg::ORIGIN_Y_RST;
			fwidth   = rsbp_pkg::FRAME_WIDTH_RST;
			fheight  = rsbp_pkg::FRAME_HEIGHT_RST;
			stride   = rsbp_pkg::ROW_STRIDE_RST;
			phase    = rsbp_pkg::PH_CMD;
			col      = 0;
			row      = 0;
			run_left = 8'd0;
			errors   = 0;
		endfunction

		function int sat_add(int a, int b);
			return (a + b > OFFSET_LIMIT) ? OFFSET_LIMIT : a + b;
		endfunction

		function void write_reg(logic [2:0] idx, logic [13:0] val);
			case (idx)
				rsbp_pkg::REG_ORIGIN_X: org_x = val[12:0];
				rsbp_pkg::REG_ORIGIN_Y: org_y = val[12:0];
				rsbp_pkg::REG_FRAME_WIDTH: fwidth = val[11:0];
				rsbp_pkg::REG_FRAME_HEIGHT: fheight = val[11:0];
				rsbp_pkg::REG_ROW_STRIDE: stride = val;
				default: ;
			endcase
		endfunction

		function void note_item(bit req, logic [7:0] b, logic [23:0] color);
			int                x;
			int                y;
			longint unsigned   a;
			logic [23:0]       c;
			pixel_write_t      w;
			if (req == REQ_LOAD) begin
				palette[b] = color;
				return;
			end
			case (phase)
				rsbp_pkg::PH_COUNT: begin
					run_left = b;
					phase = (b == 8'd0) ? rsbp_pkg::PH_CMD : rsbp_pkg::PH_PIXELS;
				end
				rsbp_pkg::PH_PIXELS: begin
					x = int'($signed(org_x)) + col;
					y = int'($signed(org_y)) + row;
					if (x >= 0 && y >= 0 && x < int'(fwidth) && y < int'(fheight)) begin
						a = longint'(y) * longint'(stride) + longint'(x) * 3;
						a = a & ((64'd1 << rsbp_pkg::ADDR_BITS) - 64'd1);
						c = palette[b];
						w.addr = a[23:0];
						w.red = c[23:16];
						w.green = c[15:8];
						w.blue = c[7:0];
						w.done = 1'b0;
						pending_writes.push_back(w);
					end
					col = sat_add(col, 1);
					run_left = run_left - 8'd1;
					if (run_left == 8'd0)
						phase = rsbp_pkg::PH_CMD;
				end
				default: begin
					if (b == rsbp_pkg::CMD_END) begin
						phase = rsbp_pkg::PH_CMD;
						col = 0;
						row = 0;
						run_left = 8'd0;
						w.addr = '0;
						w.red = '0;
						w.green = '0;
						w.blue = '0;
						w.done = 1'b1;
						pending_writes.push_back(w);
					end else if (b == rsbp_pkg::CMD_ROW) begin
						col = 0;
						row = sat_add(row, 1);
						phase = rsbp_pkg::PH_CMD;
					end else begin
						col = sat_add(col, int'(b));
						phase = rsbp_pkg::PH_COUNT;
					end
				end
			endcase
		endfunction

		function void check_write(logic [47:0] d, logic u);
			pixel_write_t w;
			if (pending_writes.size() == 0) begin
				$error("unexpected item: pixel_addr %h data %h image_done %b",
					d[23:0], d[47:24], u);
				errors++;
				return;
			end
			w = pending_writes.pop_front();
			if (d[23:0] !== w.addr) begin
				$error("pixel_addr expected %h actual %h", w.addr, d[23:0]);
				errors++;
			end
			if (d[31:24] !== w.red) begin
				$error("red expected %h actual %h", w.red, d[31:24]);
				errors++;
			end
			if (d[39:32] !== w.green) begin
				$error("green expected %h actual %h", w.green, d[39:32]);
				errors++;
			end
			if (d[47:40] !== w.blue) begin
				$error("blue expected %h actual %h", w.blue, d[47:40]);
				errors++;
			end
			if (u !== w.done) begin
				$error("image_done expected %b actual %b", w.done, u);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic        s_axis_tuser = 1'b0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [13:0] cfg_data = '0;

	blit_scoreboard sb;
	bit             steady = 1'b0;
	bit             hold_req = 1'b0;
	bit             random_loads = 1'b0;
	int             hold_left = 0;
	int             stall_cycles = 0;
	int             items_sent = 0;
	bit             loaded [rsbp_pkg::PALETTE_DEPTH];
	int             loaded_list [$];

	rle_sprite_blitter_palette_rgb24 dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = steady || ($urandom_range(0, 99) >= 7);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_write(m_axis_tdata, m_axis_tuser);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("testbench: errors");
				$finish;
			end
		end
	end

	task automatic offer_item(bit req, logic [7:0] b, logic [23:0] color);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 7) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = req;
		s_axis_tdata = {color, b};
		do
			@(posedge clk);
		while (!s_axis_tready);
		sb.note_item(req, b, color);
		items_sent++;
	endtask

	task automatic load_palette(logic [7:0] idx, logic [23:0] color);
		offer_item(REQ_LOAD, idx, color);
		if (!loaded[idx]) begin
			loaded[idx] = 1'b1;
			loaded_list.push_back(int'(idx));
		end
	endtask

	task automatic send_stream_byte(logic [7:0] b);
		if (random_loads && $urandom_range(0, 99) < 8)
			load_palette(8'($urandom_range(0, 255)), 24'($urandom));
		offer_item(REQ_STREAM, b, 24'($urandom));
	endtask

	function automatic logic [7:0] pick_index();
		return 8'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
	endfunction

	task automatic send_run(int skip, int count);
		send_stream_byte(8'(skip));
		send_stream_byte(8'(count));
		repeat (count) send_stream_byte(pick_index());
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.pending_writes.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [13:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.write_reg(idx, val);
	endtask

	task automatic configure(int ox, int oy, int fw, int fh, int st);
		write_reg(rsbp_pkg::REG_ROW_STRIDE + 3'($urandom_range(1, 3)), 14'($urandom));
		write_reg(rsbp_pkg::REG_ORIGIN_X, 14'(ox));
		write_reg(rsbp_pkg::REG_ORIGIN_Y, 14'(oy));
		write_reg(rsbp_pkg::REG_FRAME_WIDTH, 14'(fw));
		write_reg(rsbp_pkg::REG_FRAME_HEIGHT, 14'(fh));
		write_reg(rsbp_pkg::REG_ROW_STRIDE, 14'(st));
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic configure_profile(int p);
		case (p)
			0: configure(0, 0, 640, 480, 1920);
			1: begin
				if ($urandom_range(0, 1) == 0)
					configure(-4096, -4096, 4095, 4095, 16383);
				else
					configure(4095, 4095, 4095, 4095, 0);
			end
			2: configure(int'($urandom_range(0, 50)) - 20, int'($urandom_range(0, 20)) - 5,
				$urandom_range(1, 40), $urandom_range(1, 12), $urandom_range(0, 16383));
			3: begin
				if ($urandom_range(0, 1) == 0)
					configure(0, 0, 0, $urandom_range(1, 4095), $urandom_range(0, 16383));
				else
					configure(0, 0, $urandom_range(1, 4095), 0, $urandom_range(0, 16383));
			end
			default: configure($urandom_range(0, 16383), $urandom_range(0, 16383),
				$urandom_range(0, 16383), $urandom_range(0, 16383), $urandom_range(0, 16383));
		endcase
	endtask

	function automatic int pick_skip();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 6);
		if (r < 90)
			return $urandom_range(0, 40);
		return $urandom_range(0, 253);
	endfunction

	function automatic int pick_count();
		int r;
		r = $urandom_range(0, 99);
		if (r < 80)
			return $urandom_range(0, 8);
		if (r < 95)
			return $urandom_range(0, 40);
		return $urandom_range(0, 255);
	endfunction

	initial begin
		int phase_end;
		int r;
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		load_palette(8'h00, 24'h000000);
		load_palette(8'hFF, 24'hFFFFFF);
		load_palette(rsbp_pkg::CMD_ROW, 24'h5AA5C3);
		load_palette(8'h5A, 24'hA53C0F);
		offer_item(REQ_STREAM, 8'd0, 24'hFFFFFF);
		offer_item(REQ_STREAM, 8'd4, 24'h000000);
		offer_item(REQ_STREAM, 8'h00, 24'h000000);
		offer_item(REQ_STREAM, 8'hFF, 24'h000000);
		offer_item(REQ_STREAM, rsbp_pkg::CMD_ROW, 24'h000000);
		offer_item(REQ_STREAM, 8'h5A, 24'h000000);
		// A zero run count returns straight to the command phase.
		offer_item(REQ_STREAM, 8'd5, 24'h000000);
		offer_item(REQ_STREAM, 8'd0, 24'h000000);
		offer_item(REQ_STREAM, rsbp_pkg::CMD_ROW, 24'h000000);
		offer_item(REQ_STREAM, 8'd1, 24'h000000);
		offer_item(REQ_STREAM, 8'd2, 24'h000000);
		offer_item(REQ_STREAM, 8'hFF, 24'h000000);
		load_palette(8'hFF, 24'h123456);
		offer_item(REQ_STREAM, 8'hFF, 24'h000000);
		offer_item(REQ_STREAM, rsbp_pkg::CMD_END, 24'h000000);
		wait_drained();

		// Pixels left of and right of a one-pixel frame are clipped.
		configure(-2, 0, 1, 1, 1920);
		offer_item(REQ_STREAM, 8'd0, 24'h000000);
		offer_item(REQ_STREAM, 8'd4, 24'h000000);
		repeat (4) offer_item(REQ_STREAM, pick_index(), 24'($urandom));

		random_loads = 1'b1;
		for (int ph = 0; ph < PHASE_COUNT; ph++) begin
			wait_drained();
			configure_profile(ph < 5 ? ph : $urandom_range(0, 4));
			steady = (ph == 5);
			if (ph == 2)
				hold_req = 1'b1;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				r = $urandom_range(0, 99);
				if (r < 8)
					send_stream_byte(rsbp_pkg::CMD_END);
				else if (r < 22)
					send_stream_byte(rsbp_pkg::CMD_ROW);
				else
					send_run(pick_skip(), pick_count());
			end
		end
		steady = 1'b0;

		wait_drained();
		repeat (10) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end
endmodule

// File: files.f
+incdir+src
src/rsbp_pkg.sv
src/rsbp_cfg_regs.sv
src/rsbp_palette.sv
src/rsbp_decode.sv
src/rle_sprite_blitter_palette_rgb24.sv
sim/testbench.sv
